### hdl/thermistor_rms_temperature_defines.svh
// Assertion macros for the thermistor RMS temperature block.
`ifndef THERMISTOR_RMS_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_RMS_TEMPERATURE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/trt_pkg.sv
// Shared types, constants and command codes of the thermistor RMS block.
package trt_pkg;

  localparam int ADC_BITS   = 10;
  localparam int MAX_WINDOW = 64;
  localparam int FRAC_BITS  = 16;

  localparam int WHOLE_W    = 9;
  localparam int TENTHS_W   = 4;
  localparam int WIN_W      = 7;
  localparam int OHM_W      = 16;
  localparam int NK_W       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ADC_BITS-1:0] SAMPLE_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_K   = 3'd4;

  localparam logic [WIN_W-1:0] WINDOW_RST  = 7'd20;
  localparam logic [OHM_W-1:0] SERIES_RST  = 16'd4400;
  localparam logic [OHM_W-1:0] NOMINAL_RST = 16'd4700;
  localparam logic [OHM_W-1:0] BETA_RST    = 16'd10540;
  localparam logic [NK_W-1:0]  NOM_K_RST   = 9'd297;

  localparam logic [31:0] LN2_Q32       = 32'd2977044472;
  localparam int          KELVIN_OFFSET = 273;
  localparam logic [37:0] CEL_OFFSET    = 38'(KELVIN_OFFSET << FRAC_BITS);
  localparam logic [37:0] CEL_OFFSET_M1 = CEL_OFFSET - 38'd1;
  localparam logic [31:0] DEGEN_MAG     = 32'(KELVIN_OFFSET << FRAC_BITS);

  localparam int SQ_STEPS       = FRAC_BITS - 1;
  localparam int TEMP_DIV_STEPS = 36;
  localparam int MEAN_DIV_STEPS = 32;
  localparam int ROOT_STEPS     = 20;

  // datapath operations
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_LOGA_LD   = 5'd2;
  localparam logic [4:0] OP_LOGB_LD   = 5'd3;
  localparam logic [4:0] OP_NORM      = 5'd4;
  localparam logic [4:0] OP_SQ_FIRST  = 5'd5;
  localparam logic [4:0] OP_SQ_STEP   = 5'd6;
  localparam logic [4:0] OP_LOGA_FIN  = 5'd7;
  localparam logic [4:0] OP_LOGB_FIN  = 5'd8;
  localparam logic [4:0] OP_DIFF      = 5'd9;
  localparam logic [4:0] OP_LN_MUL    = 5'd10;
  localparam logic [4:0] OP_NK_MUL    = 5'd11;
  localparam logic [4:0] OP_DEN       = 5'd12;
  localparam logic [4:0] OP_ABS       = 5'd13;
  localparam logic [4:0] OP_DIV_LD    = 5'd14;
  localparam logic [4:0] OP_DIV_STEP  = 5'd15;
  localparam logic [4:0] OP_CELS      = 5'd16;
  localparam logic [4:0] OP_MAG       = 5'd17;
  localparam logic [4:0] OP_DEGEN     = 5'd18;
  localparam logic [4:0] OP_SQUARE    = 5'd19;
  localparam logic [4:0] OP_ACC       = 5'd20;
  localparam logic [4:0] OP_MEAN_LD   = 5'd21;
  localparam logic [4:0] OP_ROOT_LD1  = 5'd22;
  localparam logic [4:0] OP_ROOT_STEP = 5'd23;
  localparam logic [4:0] OP_ROOT_FIN1 = 5'd24;
  localparam logic [4:0] OP_ROOT_LD2  = 5'd25;
  localparam logic [4:0] OP_OUT       = 5'd26;

  typedef struct packed {
    logic [4:0] op;
  } trt_cmd_t;

  typedef struct packed {
    logic degen;
    logic x_norm;
    logic huge;
    logic win_done;
    logic out_free;
  } trt_stat_t;

endpackage

### hdl/trt_if.sv
// Sample and result channel interfaces.
interface trt_in_if;
  logic                         valid;
  logic                         ready;
  logic [trt_pkg::ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface trt_out_if;
  logic                         valid;
  logic                         ready;
  logic [trt_pkg::WHOLE_W-1:0]  rms_whole;
  logic [trt_pkg::TENTHS_W-1:0] rms_tenths;

  modport source (output valid, output rms_whole, output rms_tenths, input ready);
  modport sink (input valid, input rms_whole, input rms_tenths, output ready);
endinterface

### hdl/thermistor_rms_temperature.sv
// Thermistor RMS temperature: controller plus datapath.
// Usage:
//   samples carries one 10-bit ADC reading per item (valid/ready). Each item
//   is turned into degrees Celsius by the Beta equation and its square is
//   added to a window sum. When window_length items (0 taken as 1, capped at
//   64) are taken, one item with rms_whole and rms_tenths goes out on results.
//   The configuration port writes register cfg_index with cfg_data on
//   cfg_write; write only while the block is idle.
// Sequence:
//   A normal sample runs the two log units' normalization shift steps, the
//   16 squarings of each log and the 36-step restoring divider; a Kelvin
//   quotient out of range skips the divider. A fully open divider or a
//   zero register skips both logs and the divider. The item that closes a
//   window adds a 32-step mean division and two 20-step square roots.
//   samples.ready is high only out of reset while no sample is in work.
// Reset: registers return to their default values, count and sum clear.
// Stall: the result sits in an output register; samples go on while the
//   receiver holds it, but the next window result then waits, and no sample
//   is taken, until the register is free.
module thermistor_rms_temperature (
  input  logic                           clk,
  input  logic                           rst,
  trt_in_if.sink                         samples,
  trt_out_if.source                      results,
  input  logic                           cfg_write,
  input  logic [trt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trt_pkg::CFG_DATA_W-1:0] cfg_data
);

  trt_pkg::trt_cmd_t  cmd;
  trt_pkg::trt_stat_t stat;

  trt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  trt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .adc_sample (samples.adc_sample),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .rms_whole  (results.rms_whole),
    .rms_tenths (results.rms_tenths)
  );

endmodule

### hdl/trt_ctrl.sv
// Sequencer that steps the datapath through one sample and the window result.
`include "thermistor_rms_temperature_defines.svh"

module trt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output trt_pkg::trt_cmd_t  cmd,
  input  trt_pkg::trt_stat_t stat
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CHK    = 5'd1;
  localparam logic [4:0] ST_LD     = 5'd2;
  localparam logic [4:0] ST_NRM    = 5'd3;
  localparam logic [4:0] ST_SQ     = 5'd4;
  localparam logic [4:0] ST_FIN    = 5'd5;
  localparam logic [4:0] ST_DIFF   = 5'd6;
  localparam logic [4:0] ST_LNM    = 5'd7;
  localparam logic [4:0] ST_NKM    = 5'd8;
  localparam logic [4:0] ST_DEN    = 5'd9;
  localparam logic [4:0] ST_ABS    = 5'd10;
  localparam logic [4:0] ST_DIVLD  = 5'd11;
  localparam logic [4:0] ST_TDIV   = 5'd12;
  localparam logic [4:0] ST_CELS   = 5'd13;
  localparam logic [4:0] ST_MAG    = 5'd14;
  localparam logic [4:0] ST_DEGEN  = 5'd15;
  localparam logic [4:0] ST_SQUARE = 5'd16;
  localparam logic [4:0] ST_ACC    = 5'd17;
  localparam logic [4:0] ST_MLD    = 5'd18;
  localparam logic [4:0] ST_MDIV   = 5'd19;
  localparam logic [4:0] ST_RLD1   = 5'd20;
  localparam logic [4:0] ST_RT1    = 5'd21;
  localparam logic [4:0] ST_RF1    = 5'd22;
  localparam logic [4:0] ST_RLD2   = 5'd23;
  localparam logic [4:0] ST_RT2    = 5'd24;
  localparam logic [4:0] ST_OUT    = 5'd25;

  logic [4:0] state, state_next;
  logic [5:0] step, step_next;
  logic       second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    second_next = second;
    in_ready    = 1'b0;
    cmd.op      = trt_pkg::OP_NOP;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op     = trt_pkg::OP_LOAD;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        second_next = 1'b0;
        state_next  = stat.degen ? ST_DEGEN : ST_LD;
      end
      ST_LD: begin
        cmd.op     = second ? trt_pkg::OP_LOGB_LD : trt_pkg::OP_LOGA_LD;
        state_next = ST_NRM;
      end
      ST_NRM: begin
        if (stat.x_norm) begin
          cmd.op     = trt_pkg::OP_SQ_FIRST;
          step_next  = '0;
          state_next = ST_SQ;
        end else begin
          cmd.op = trt_pkg::OP_NORM;
        end
      end
      ST_SQ: begin
        cmd.op    = trt_pkg::OP_SQ_STEP;
        step_next = step + 6'd1;
        if (step == 6'(trt_pkg::SQ_STEPS - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = second ? trt_pkg::OP_LOGB_FIN : trt_pkg::OP_LOGA_FIN;
        if (second) begin
          state_next = ST_DIFF;
        end else begin
          second_next = 1'b1;
          state_next  = ST_LD;
        end
      end
      ST_DIFF: begin
        cmd.op     = trt_pkg::OP_DIFF;
        state_next = ST_LNM;
      end
      ST_LNM: begin
        cmd.op     = trt_pkg::OP_LN_MUL;
        state_next = ST_NKM;
      end
      ST_NKM: begin
        cmd.op     = trt_pkg::OP_NK_MUL;
        state_next = ST_DEN;
      end
      ST_DEN: begin
        cmd.op     = trt_pkg::OP_DEN;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.op     = trt_pkg::OP_ABS;
        state_next = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd.op     = trt_pkg::OP_DIV_LD;
        step_next  = '0;
        state_next = ST_TDIV;
      end
      ST_TDIV: begin
        // quotient out of range or zero denominator: sum saturates
        if (stat.huge) begin
          state_next = ST_ACC;
        end else begin
          cmd.op    = trt_pkg::OP_DIV_STEP;
          step_next = step + 6'd1;
          if (step == 6'(trt_pkg::TEMP_DIV_STEPS - 1)) state_next = ST_CELS;
        end
      end
      ST_CELS: begin
        cmd.op     = trt_pkg::OP_CELS;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.op     = trt_pkg::OP_MAG;
        state_next = ST_SQUARE;
      end
      ST_DEGEN: begin
        cmd.op     = trt_pkg::OP_DEGEN;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.op     = trt_pkg::OP_SQUARE;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op     = trt_pkg::OP_ACC;
        state_next = stat.win_done ? ST_MLD : ST_IDLE;
      end
      ST_MLD: begin
        cmd.op     = trt_pkg::OP_MEAN_LD;
        step_next  = '0;
        state_next = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.op    = trt_pkg::OP_DIV_STEP;
        step_next = step + 6'd1;
        if (step == 6'(trt_pkg::MEAN_DIV_STEPS - 1)) state_next = ST_RLD1;
      end
      ST_RLD1: begin
        cmd.op     = trt_pkg::OP_ROOT_LD1;
        step_next  = '0;
        state_next = ST_RT1;
      end
      ST_RT1: begin
        cmd.op    = trt_pkg::OP_ROOT_STEP;
        step_next = step + 6'd1;
        if (step == 6'(trt_pkg::ROOT_STEPS - 1)) state_next = ST_RF1;
      end
      ST_RF1: begin
        cmd.op     = trt_pkg::OP_ROOT_FIN1;
        state_next = ST_RLD2;
      end
      ST_RLD2: begin
        cmd.op     = trt_pkg::OP_ROOT_LD2;
        step_next  = '0;
        state_next = ST_RT2;
      end
      ST_RT2: begin
        cmd.op    = trt_pkg::OP_ROOT_STEP;
        step_next = step + 6'd1;
        if (step == 6'(trt_pkg::ROOT_STEPS - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = trt_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `TRT_ASSERT_SAME(a_out_free, cmd.op == trt_pkg::OP_OUT, stat.out_free, "result overwrite")
  `TRT_ASSERT_NEXT(a_acc_idle, state == ST_ACC && !stat.win_done, state == ST_IDLE, "no idle")
  `TRT_ASSERT_SAME(a_tdiv_bound, state == ST_TDIV, step < 6'(trt_pkg::TEMP_DIV_STEPS), "overrun")

endmodule

### hdl/trt_datapath.sv
// Datapath: config registers, shared multiplier, log, divider, root and accumulator.
module trt_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [trt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [trt_pkg::ADC_BITS-1:0]       adc_sample,
  input  trt_pkg::trt_cmd_t                  cmd,
  output trt_pkg::trt_stat_t                 stat,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [trt_pkg::WHOLE_W-1:0]        rms_whole,
  output logic [trt_pkg::TENTHS_W-1:0]       rms_tenths
);

  logic [trt_pkg::WIN_W-1:0] window_length;
  logic [trt_pkg::OHM_W-1:0] series_ohms, nominal_ohms, beta_kelvin;
  logic [trt_pkg::NK_W-1:0]  nominal_kelvin;

  logic [trt_pkg::ADC_BITS-1:0] raw;
  logic [63:0] prod;
  logic [31:0] x;
  logic [4:0]  p;
  logic [14:0] bits;
  logic [20:0] la, lb, dm;
  logic        lneg, kneg, huge;
  logic [33:0] den;
  logic [32:0] dvs, rem;
  logic [35:0] dshift, quo;
  logic [37:0] cel;
  logic [31:0] mag, sum;
  logic [6:0]  count;
  logic [39:0] sx;
  logic [19:0] root;
  logic [21:0] srem;
  logic [15:0] whole;

  // combinational helpers
  logic [trt_pkg::ADC_BITS-1:0] v;
  logic [trt_pkg::ADC_BITS:0]   raw_p1;
  logic [31:0] ma, mb, m_next;
  logic [63:0] mp;
  logic [21:0] diff;
  logic [33:0] den_next, den_abs, beta_sh, nkl;
  logic [33:0] div_t, div_diff;
  logic        div_ge, big_cmp;
  logic [37:0] qx, cel_abs;
  logic [6:0]  n_eff, count_inc;
  logic        win_done;
  logic [31:0] sq_val, sum_sat;
  logic [32:0] total;
  logic [23:0] rt_t, rt_diff;
  logic [21:0] trial;
  logic        rt_ge;
  logic [19:0] ten_w;
  logic [3:0]  tenths_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= trt_pkg::WINDOW_RST;
      series_ohms    <= trt_pkg::SERIES_RST;
      nominal_ohms   <= trt_pkg::NOMINAL_RST;
      beta_kelvin    <= trt_pkg::BETA_RST;
      nominal_kelvin <= trt_pkg::NOM_K_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        trt_pkg::REG_WINDOW:  window_length  <= cfg_data[trt_pkg::WIN_W-1:0];
        trt_pkg::REG_SERIES:  series_ohms    <= cfg_data;
        trt_pkg::REG_NOMINAL: nominal_ohms   <= cfg_data;
        trt_pkg::REG_BETA:    beta_kelvin    <= cfg_data;
        trt_pkg::REG_NOM_K:   nominal_kelvin <= cfg_data[trt_pkg::NK_W-1:0];
        default: ;
      endcase
    end
  end

  assign v      = trt_pkg::SAMPLE_MAX - raw;
  assign raw_p1 = {1'b0, raw} + 11'd1;
  // next mantissa of the log squaring loop, renormalized into [2^31, 2^32)
  assign m_next = prod[63] ? prod[63:32] : prod[62:31];
  assign diff   = {1'b0, la} - {1'b0, lb};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      trt_pkg::OP_LOGA_LD: begin
        ma = {16'b0, nominal_ohms};
        mb = {21'b0, raw_p1};
      end
      trt_pkg::OP_LOGB_LD: begin
        ma = {16'b0, series_ohms};
        mb = {22'b0, v};
      end
      trt_pkg::OP_SQ_FIRST: begin
        ma = x;
        mb = x;
      end
      trt_pkg::OP_SQ_STEP: begin
        ma = m_next;
        mb = m_next;
      end
      trt_pkg::OP_LN_MUL: begin
        ma = {11'b0, dm};
        mb = trt_pkg::LN2_Q32;
      end
      trt_pkg::OP_NK_MUL: begin
        ma = {23'b0, nominal_kelvin};
        mb = {11'b0, prod[52:32]};
      end
      trt_pkg::OP_DEN: begin
        ma = {23'b0, nominal_kelvin};
        mb = {16'b0, beta_kelvin};
      end
      trt_pkg::OP_SQUARE: begin
        ma = mag;
        mb = mag;
      end
      trt_pkg::OP_ROOT_FIN1: begin
        ma = quo[31:0];
        mb = 32'd100;
      end
      default: ;
    endcase
  end

  assign mp = {32'b0, ma} * {32'b0, mb};

  assign beta_sh  = {2'b0, beta_kelvin, 16'b0};
  assign nkl      = {4'b0, prod[29:0]};
  assign den_next = lneg ? (beta_sh - nkl) : (beta_sh + nkl);
  assign den_abs  = den[33] ? (~den + 34'd1) : den;

  // quotient must stay below 2^36; a zero divisor also lands here
  assign big_cmp  = {12'b0, prod[24:0], 16'b0} >= {dvs, 20'b0};

  assign div_t    = {rem, dshift[35]};
  assign div_ge   = div_t >= {1'b0, dvs};
  assign div_diff = div_t - {1'b0, dvs};

  assign qx      = {2'b0, quo};
  assign cel_abs = cel[37] ? (~cel + 38'd1) : cel;

  assign n_eff = (window_length == '0) ? 7'd1 :
                 (window_length > 7'(trt_pkg::MAX_WINDOW)) ? 7'(trt_pkg::MAX_WINDOW) :
                 window_length;
  assign count_inc = count + 7'd1;
  assign win_done  = count_inc >= n_eff;
  assign sq_val    = huge ? '1 : prod[63:32];
  assign total     = {1'b0, sum} + {1'b0, sq_val};
  assign sum_sat   = total[32] ? '1 : total[31:0];

  assign trial   = {root, 2'b01};
  assign rt_t    = {srem, sx[39:38]};
  assign rt_ge   = rt_t >= {2'b0, trial};
  assign rt_diff = rt_t - {2'b0, trial};

  assign ten_w      = {root[16:0] & 17'b0, 3'b0} | ({whole, 3'b0} + {3'b0, whole, 1'b0});
  assign tenths_raw = root[3:0] - ten_w[3:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      trt_pkg::OP_LOAD: raw <= adc_sample;
      trt_pkg::OP_LOGA_LD, trt_pkg::OP_LOGB_LD: begin
        x <= mp[31:0];
        p <= 5'd31;
      end
      trt_pkg::OP_NORM: begin
        if (x[31:24] == 8'd0) begin
          x <= {x[23:0], 8'b0};
          p <= p - 5'd8;
        end else begin
          x <= {x[30:0], 1'b0};
          p <= p - 5'd1;
        end
      end
      trt_pkg::OP_SQ_FIRST: prod <= mp;
      trt_pkg::OP_SQ_STEP: begin
        bits <= {bits[13:0], prod[63]};
        prod <= mp;
      end
      trt_pkg::OP_LOGA_FIN: la <= {p, bits, prod[63]};
      trt_pkg::OP_LOGB_FIN: lb <= {p, bits, prod[63]};
      trt_pkg::OP_DIFF: begin
        dm   <= diff[21] ? 21'(~diff + 22'd1) : diff[20:0];
        lneg <= diff[21];
      end
      trt_pkg::OP_LN_MUL, trt_pkg::OP_NK_MUL, trt_pkg::OP_SQUARE: prod <= mp;
      trt_pkg::OP_DEN: begin
        den  <= den_next;
        prod <= mp;
      end
      trt_pkg::OP_ABS: begin
        dvs   <= den_abs[32:0];
        kneg  <= den[33];
      end
      trt_pkg::OP_DIV_LD: begin
        rem    <= {12'b0, prod[24:4]};
        dshift <= {prod[3:0], 32'b0};
      end
      trt_pkg::OP_DIV_STEP: begin
        rem    <= div_ge ? div_diff[32:0] : div_t[32:0];
        quo    <= {quo[34:0], div_ge};
        dshift <= {dshift[34:0], 1'b0};
      end
      // -q - K is ~q - (K - 1)
      trt_pkg::OP_CELS: cel <= kneg ? (~qx - trt_pkg::CEL_OFFSET_M1) : (qx - trt_pkg::CEL_OFFSET);
      trt_pkg::OP_MAG: mag <= cel_abs[31:0];
      trt_pkg::OP_DEGEN: mag <= trt_pkg::DEGEN_MAG;
      trt_pkg::OP_MEAN_LD: begin
        rem    <= '0;
        dvs    <= {26'b0, n_eff};
        dshift <= {sum, 4'b0};
      end
      trt_pkg::OP_ROOT_LD1: begin
        sx   <= {8'b0, quo[31:0]};
        root <= '0;
        srem <= '0;
      end
      trt_pkg::OP_ROOT_STEP: begin
        sx   <= {sx[37:0], 2'b0};
        srem <= rt_ge ? rt_diff[21:0] : rt_t[21:0];
        root <= {root[18:0], rt_ge};
      end
      trt_pkg::OP_ROOT_FIN1: begin
        whole <= root[15:0];
        prod  <= mp;
      end
      trt_pkg::OP_ROOT_LD2: begin
        sx   <= prod[39:0];
        root <= '0;
        srem <= '0;
      end
      trt_pkg::OP_OUT: begin
        if (whole[15:9] != 7'd0) begin
          rms_whole  <= '1;
          rms_tenths <= 4'd9;
        end else begin
          rms_whole  <= whole[8:0];
          rms_tenths <= tenths_raw;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      huge <= 1'b0;
    end else begin
      case (cmd.op)
        trt_pkg::OP_LOAD:   huge <= 1'b0;
        trt_pkg::OP_DIV_LD: huge <= big_cmp;
        trt_pkg::OP_MAG:    huge <= cel_abs[37:32] != 6'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.op == trt_pkg::OP_ACC) begin
      sum   <= sum_sat;
      count <= win_done ? 7'd0 : count_inc;
    end else if (cmd.op == trt_pkg::OP_MEAN_LD) begin
      sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == trt_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.degen    = (raw == trt_pkg::SAMPLE_MAX) || (series_ohms == '0) ||
                         (nominal_ohms == '0) || (beta_kelvin == '0) ||
                         (nominal_kelvin == '0);
  assign stat.x_norm   = x[31];
  assign stat.huge     = huge;
  assign stat.win_done = win_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

### sim/trt_tb_if.sv
// Test helper package: the result record that the scoreboard queues.
package trt_tb_pkg;
  import trt_pkg::*;

  typedef struct {
    logic [WHOLE_W-1:0]  whole;
    logic [TENTHS_W-1:0] tenths;
  } rms_result_t;
endpackage

### sim/tb_top.sv
// Self-checking bench for the thermistor RMS block: random samples, config sweeps, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trt_pkg::*;
  import trt_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trt_in_if  samples();
  trt_out_if results();

  thermistor_rms_temperature dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [WIN_W-1:0] win_reg;
  logic [OHM_W-1:0] series_reg, nominal_reg, beta_reg;
  logic [NK_W-1:0]  nomk_reg;
  int unsigned window_fill;
  logic [31:0] square_total;

  logic [ADC_BITS-1:0] sample_queue[$];
  rms_result_t rms_expected[$];
  int errors = 0;
  int results_seen = 0;
  int samples_sent = 0;

  function automatic longint log2_q(longint unsigned x);
    int p = 0;
    longint unsigned m, bits = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      bits = bits << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        bits = bits | 64'd1;
      end
    end
    return longint'((longint'(p) << FRAC_BITS) | bits);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0, t;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned celsius_square(logic [ADC_BITS-1:0] raw);
    longint unsigned v, dm, dabs, num, q, r, mag, ip, fr;
    longint diff, lnv, den, cel;
    v = longint'(SAMPLE_MAX) - raw;
    if (v == 0 || series_reg == 0 || nominal_reg == 0 || beta_reg == 0 || nomk_reg == 0)
      cel = -(longint'(KELVIN_OFFSET) << FRAC_BITS);
    else begin
      diff = log2_q(64'(nominal_reg) * (64'(raw) + 64'd1)) - log2_q(64'(series_reg) * v);
      dm = diff < 0 ? longint'(-diff) : diff;
      lnv = longint'((dm * 64'(LN2_Q32)) >> 32);
      if (diff < 0) lnv = -lnv;
      den = (longint'(beta_reg) << FRAC_BITS) + longint'(nomk_reg) * lnv;
      if (den == 0) return 64'hFFFF_FFFF;
      dabs = den < 0 ? -den : den;
      num = (64'(nomk_reg) * 64'(beta_reg)) << FRAC_BITS;
      q = num / dabs;
      r = num % dabs;
      if (q >= (64'd1 << 20)) return 64'hFFFF_FFFF;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= dabs) begin
          r = r - dabs;
          q = q | 64'd1;
        end
      end
      cel = (den < 0 ? -longint'(q) : longint'(q)) - (longint'(KELVIN_OFFSET) << FRAC_BITS);
    end
    mag = cel < 0 ? -cel : cel;
    ip = mag >> FRAC_BITS;
    if (ip >= 65536) return 64'hFFFF_FFFF;
    fr = mag & ((64'd1 << FRAC_BITS) - 64'd1);
    return ip * ip + ((64'd2 * ip * fr + ((fr * fr) >> FRAC_BITS)) >> FRAC_BITS);
  endfunction

  task automatic accumulate_sample(logic [ADC_BITS-1:0] raw);
    longint unsigned total, mean, whole, tenths;
    int unsigned n;
    rms_result_t res;
    total = 64'(square_total) + celsius_square(raw);
    square_total = total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
    n = win_reg;
    if (n < 1) n = 1;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    window_fill = (window_fill + 1) & 8'hFF;
    if (window_fill < n) return;
    mean = square_total / n;
    whole = int_sqrt(mean);
    tenths = int_sqrt(mean * 100) - 10 * whole;
    if (whole > 511) begin
      whole = 511;
      tenths = 9;
    end
    res.whole = whole[WHOLE_W-1:0];
    res.tenths = tenths[TENTHS_W-1:0];
    rms_expected.push_back(res);
    window_fill = 0;
    square_total = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WINDOW:  win_reg = val[WIN_W-1:0];
      REG_SERIES:  series_reg = val;
      REG_NOMINAL: nominal_reg = val;
      REG_BETA:    beta_reg = val;
      REG_NOM_K:   nomk_reg = val[NK_W-1:0];
      default: ;
    endcase
  endtask

  // driver
  int send_gap = 0;
  initial begin
    samples.valid = 1'b0;
    samples.adc_sample = '0;
  end
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      accumulate_sample(samples.adc_sample);
      samples_sent++;
      send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (send_gap == 0 && sample_queue.size() > 0) begin
        samples.adc_sample <= sample_queue.pop_front();
      end else begin
        samples.valid <= 1'b0;
      end
    end else if (!samples.valid) begin
      if (send_gap > 0) send_gap--;
      else if (sample_queue.size() > 0) begin
        samples.valid <= 1'b1;
        samples.adc_sample <= sample_queue.pop_front();
      end
    end
  end

  // monitor
  int stall = 0;
  initial results.ready = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results_seen++;
        if (rms_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result whole=%0d tenths=%0d", $time,
                   results.rms_whole, results.rms_tenths);
        end else begin
          rms_result_t e;
          e = rms_expected.pop_front();
          if (e.whole !== results.rms_whole) begin
            errors++;
            $display("%0t: rms_whole expected %0d actual %0d", $time, e.whole,
                     results.rms_whole);
          end
          if (e.tenths !== results.rms_tenths) begin
            errors++;
            $display("%0t: rms_tenths expected %0d actual %0d", $time, e.tenths,
                     results.rms_tenths);
          end
        end
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
        results.ready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        results.ready <= (stall == 0);
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (sample_queue.size() > 0 || samples.valid || rms_expected.size() > 0)
      @(posedge clk);
    // a sample that closes no window may still be in work
    repeat (200) @(posedge clk);
  endtask

  task automatic load_phase(int count, int mode);
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: sample_queue.push_back(10'($urandom_range(0, 1023)));
        1: sample_queue.push_back(10'($urandom_range(300, 800)));
        default: sample_queue.push_back($urandom_range(0, 7) == 0 ? SAMPLE_MAX :
                                        10'($urandom_range(0, 1023)));
      endcase
    end
  endtask

  initial begin
    int phase_items;
    int win_eff;
    win_reg = WINDOW_RST;
    series_reg = SERIES_RST;
    nominal_reg = NOMINAL_RST;
    beta_reg = BETA_RST;
    nomk_reg = NOM_K_RST;
    window_fill = 0;
    square_total = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases at reset settings, window of 1
    write_reg(REG_WINDOW, 16'd1);
    sample_queue.push_back(10'd0);
    sample_queue.push_back(10'd1);
    sample_queue.push_back(10'd511);
    sample_queue.push_back(10'd512);
    sample_queue.push_back(10'd1022);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(10'h2AA);
    sample_queue.push_back(10'h155);
    drain();
    // window 0 clamps to 1, zero nominal gives -273
    write_reg(REG_WINDOW, 16'd0);
    write_reg(REG_NOMINAL, 16'd0);
    sample_queue.push_back(10'd400);
    drain();
    // window above max clamps; extreme register values
    write_reg(REG_WINDOW, 16'd127);
    write_reg(REG_NOMINAL, 16'd65535);
    write_reg(REG_SERIES, 16'd1);
    write_reg(REG_BETA, 16'd1);
    write_reg(REG_NOM_K, 16'd511);
    load_phase(64, 0);
    drain();
    // denominator of either sign
    write_reg(REG_WINDOW, 16'd2);
    write_reg(REG_BETA, 16'd10);
    write_reg(REG_NOM_K, 16'd1);
    write_reg(REG_SERIES, 16'd65535);
    write_reg(REG_NOMINAL, 16'd1);
    load_phase(6, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_WINDOW, (ph % 4 == 0) ? 16'd1 : (ph % 4 == 1) ? 16'd64 :
                16'($urandom_range(0, 127)));
      write_reg(REG_SERIES, (ph == 3) ? 16'hFFFF : (ph < 6) ? SERIES_RST :
                16'($urandom_range(1, 65535)));
      write_reg(REG_NOMINAL, (ph == 4) ? 16'd1 : (ph < 6) ? NOMINAL_RST :
                16'($urandom_range(1, 65535)));
      write_reg(REG_BETA, (ph == 5) ? 16'hFFFF : (ph < 6) ? BETA_RST :
                16'($urandom_range(1, 65535)));
      write_reg(REG_NOM_K, (ph == 6) ? 16'h01FF : (ph < 6) ? 16'(NOM_K_RST) :
                16'($urandom_range(1, 511)));
      win_eff = (win_reg == '0) ? 1 : (win_reg > WIN_W'(MAX_WINDOW)) ? MAX_WINDOW :
                int'(win_reg);
      phase_items = (win_eff > 30) ? 2 * win_eff : 60;
      load_phase(phase_items, ph % 3);
      drain();
    end
    write_reg(REG_WINDOW, 16'd5);
    write_reg(REG_SERIES, SERIES_RST);
    write_reg(REG_NOMINAL, NOMINAL_RST);
    write_reg(REG_BETA, BETA_RST);
    write_reg(REG_NOM_K, 16'(NOM_K_RST));
    load_phase(50, 1);
    drain();

    $display("Covered %0d samples and %0d RMS results over directed and random settings.",
             samples_sent, results_seen);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/trt_pkg.sv
hdl/trt_if.sv
hdl/trt_ctrl.sv
hdl/trt_datapath.sv
hdl/thermistor_rms_temperature.sv
sim/trt_tb_if.sv
sim/tb_top.sv
